// ===== rtl/bmhq_pkg.sv =====
`default_nettype none
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

// ===== rtl/bmhq_cmd_if.sv =====
`default_nettype none
interface bmhq_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic signed [bmhq_pkg::DATA_W-1:0]    value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmhq_rsp_if.sv =====
`default_nettype none
interface bmhq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic signed [bmhq_pkg::DATA_W-1:0]    popped_value;
    logic [bmhq_pkg::CNT_W-1:0]            entry_count;

    modport source (output valid, output status, output popped_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input entry_count,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/bmhq_ram.sv =====
`default_nettype none
module bmhq_ram (
    input  wire logic                          i_clk,
    input  wire bmhq_pkg::t_ram_req            i_req,
    output logic [bmhq_pkg::DATA_W-1:0]        o_rdata
);

    logic [bmhq_pkg::DATA_W-1:0] mem [bmhq_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= mem[i_req.raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/bmhq_cmp.sv =====
`default_nettype none
module bmhq_cmp (
    input  wire logic signed [bmhq_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [bmhq_pkg::DATA_W-1:0] i_b,
    output logic                                    o_lt
);

    assign o_lt = (i_a < i_b);

endmodule
`default_nettype wire

// ===== rtl/binary_min_heap_queue.sv =====
// A push sifts the new value up toward the root one level at a time; a pop that empties
// the heap skips the sift-down, else the last entry sifts down from the root one level
// at a time; a push to a full heap or a pop from an empty one is rejected with a status.
// One request at a time: the next is accepted only after the result has issued;
// the result register stalls the next request while the sink holds it off.
// Reset (synchronous, active low) empties the heap; memory contents are not cleared.
`default_nettype none
module binary_min_heap_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bmhq_cmd_if.sink        i_cmd,
    bmhq_rsp_if.source      o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_FIN,
        S_P_RD0,
        S_P_RDL,
        S_P_LAST,
        S_D_RDL,
        S_D_RDR,
        S_D_SEL,
        S_D_CMP,
        S_DONE
    } t_state;

    t_state                                r_state;
    logic [bmhq_pkg::CNT_W-1:0]            r_count;
    logic [bmhq_pkg::ADDR_W-1:0]           r_pos;
    logic [bmhq_pkg::ADDR_W-1:0]           r_ci;
    logic signed [bmhq_pkg::DATA_W-1:0]    r_val;
    logic signed [bmhq_pkg::DATA_W-1:0]    r_cv;
    logic signed [bmhq_pkg::DATA_W-1:0]    r_popped;
    bmhq_pkg::t_status                     r_status;

    logic                                  r_rsp_valid;
    bmhq_pkg::t_status                     r_rsp_status;
    logic signed [bmhq_pkg::DATA_W-1:0]    r_rsp_popped;
    logic [bmhq_pkg::CNT_W-1:0]            r_rsp_count;

    bmhq_pkg::t_ram_req                    ram_req;
    logic [bmhq_pkg::DATA_W-1:0]           rd_data;
    logic signed [bmhq_pkg::DATA_W-1:0]    cmp_a;
    logic signed [bmhq_pkg::DATA_W-1:0]    cmp_b;
    logic                                  cmp_lt;

    logic [bmhq_pkg::ADDR_W-1:0]           parent;
    logic [bmhq_pkg::IDX_W-1:0]            left_w;
    logic [bmhq_pkg::IDX_W-1:0]            right_w;
    logic [bmhq_pkg::IDX_W-1:0]            cnt_w;
    logic                                  accept;
    logic                                  rsp_free;

    bmhq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rd_data)
    );

    bmhq_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

    assign parent   = (r_pos - 1'b1) >> 1;
    assign left_w   = bmhq_pkg::IDX_W'({r_pos, 1'b1});
    assign right_w  = left_w + 1'b1;
    assign cnt_w    = bmhq_pkg::IDX_W'(r_count);
    assign accept   = i_cmd.valid && (r_state == S_IDLE);
    assign rsp_free = !r_rsp_valid || o_rsp.ready;

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_status;
    assign o_rsp.popped_value = r_rsp_popped;
    assign o_rsp.entry_count  = r_rsp_count;

    // shared comparator operand select
    always_comb begin
        unique case (r_state)
            S_UP_CMP: begin
                cmp_a = r_val;
                cmp_b = rd_data;
            end
            S_D_SEL: begin
                cmp_a = rd_data;
                cmp_b = r_cv;
            end
            default: begin
                cmp_a = r_cv;
                cmp_b = r_val;
            end
        endcase
    end

    // memory port: hole-based sifting, the moving value stays in r_val
    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.waddr = r_pos;
        ram_req.wdata = r_val;
        ram_req.raddr = r_pos;
        unique case (r_state)
            S_UP_RD: begin
                ram_req.raddr = parent;
            end
            S_UP_CMP: begin
                ram_req.we = 1'b1;
                if (cmp_lt) begin
                    ram_req.wdata = rd_data;
                end
            end
            S_UP_FIN: begin
                ram_req.we = 1'b1;
            end
            S_P_RD0: begin
                ram_req.raddr = '0;
            end
            S_P_RDL: begin
                ram_req.raddr = r_count[bmhq_pkg::ADDR_W-1:0];
            end
            S_D_RDL: begin
                ram_req.raddr = left_w[bmhq_pkg::ADDR_W-1:0];
                if (left_w >= cnt_w) begin
                    ram_req.we = 1'b1;
                end
            end
            S_D_RDR: begin
                ram_req.raddr = right_w[bmhq_pkg::ADDR_W-1:0];
            end
            S_D_CMP: begin
                ram_req.we = 1'b1;
                if (cmp_lt) begin
                    ram_req.wdata = r_cv;
                end
            end
            default: begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_rsp_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val    <= i_cmd.value;
                        r_popped <= '0;
                        r_status <= bmhq_pkg::ST_OK;
                        if (i_cmd.command == bmhq_pkg::CMD_PUSH) begin
                            if (r_count >= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
                                r_status <= bmhq_pkg::ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_pos   <= r_count[bmhq_pkg::ADDR_W-1:0];
                                r_count <= r_count + 1'b1;
                                r_state <= (r_count == '0) ? S_UP_FIN : S_UP_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_status <= bmhq_pkg::ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_pos   <= '0;
                                r_count <= r_count - 1'b1;
                                r_state <= S_P_RD0;
                            end
                        end
                    end
                end
                S_UP_RD: begin
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (cmp_lt) begin
                        r_pos   <= parent;
                        r_state <= (parent == '0) ? S_UP_FIN : S_UP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_UP_FIN: begin
                    r_state <= S_DONE;
                end
                S_P_RD0: begin
                    r_state <= S_P_RDL;
                end
                S_P_RDL: begin
                    r_popped <= rd_data;
                    r_state  <= S_P_LAST;
                end
                S_P_LAST: begin
                    r_val   <= rd_data;
                    r_state <= (r_count == '0) ? S_DONE : S_D_RDL;
                end
                S_D_RDL: begin
                    r_state <= (left_w >= cnt_w) ? S_DONE : S_D_RDR;
                end
                S_D_RDR: begin
                    r_cv    <= rd_data;
                    r_ci    <= left_w[bmhq_pkg::ADDR_W-1:0];
                    r_state <= (right_w < cnt_w) ? S_D_SEL : S_D_CMP;
                end
                S_D_SEL: begin
                    if (cmp_lt) begin
                        r_cv <= rd_data;
                        r_ci <= right_w[bmhq_pkg::ADDR_W-1:0];
                    end
                    r_state <= S_D_CMP;
                end
                S_D_CMP: begin
                    if (cmp_lt) begin
                        r_pos   <= r_ci;
                        r_state <= S_D_RDL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (rsp_free) begin
                        r_rsp_valid  <= 1'b1;
                        r_rsp_status <= r_status;
                        r_rsp_popped <= r_popped;
                        r_rsp_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
